>>> src/tlptm_pkg.sv
// package: types, constants and codes for the two level page table manager
package tlptm_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int ENTRIES = 1024;
  localparam int IDX_W = 10;
  localparam int STORE_W = SLOT_W + IDX_W;
  localparam int CFG_W = 20;

  localparam logic [1:0] CFG_BASE = 2'd0;
  localparam logic [1:0] CFG_KCOUNT = 2'd1;
  localparam logic [1:0] CFG_FIRST = 2'd2;

  localparam logic [2:0] ACT_XLATE = 3'd0;
  localparam logic [2:0] ACT_UCHECK = 3'd1;
  localparam logic [2:0] ACT_MAP = 3'd2;
  localparam logic [2:0] ACT_UNMAP = 3'd3;
  localparam logic [2:0] ACT_KSET = 3'd4;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NOMAP = 3'd1;
  localparam logic [2:0] ST_NOFREE = 3'd2;
  localparam logic [2:0] ST_KSHARED = 3'd3;
  localparam logic [2:0] ST_OUTSIDE = 3'd4;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] vaddr;
    logic [31:0] paddr;
    logic [11:0] flags;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] phys_out;
    logic        user_ok;
  } out_item_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DREAD, S_DEC, S_KSCAN, S_KWAIT, S_CLEAR, S_TREAD, S_TDEC, S_DONE
  } state_t;

endpackage

>>> src/two_level_page_table_manager.sv
// top level: page directory, kernel directory and table store with a walk sequencer
// for translate, check and unmap the walk reads the table only when the directory entry
// is present and inside the store; set kernel entry writes both directories
// map with a new table clears the slot; map through an existing table
// with user bit scans min(kernel_entry_count, 1024) kernel entries
// one item at a time; a result stalled at the output holds the next one
// reset is synchronous and active low, then an init pass zeroes both directories
module two_level_page_table_manager import tlptm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [31:0] dir_mem [ENTRIES];
  logic [31:0] kdir_mem [ENTRIES];
  logic [31:0] store_mem [TABLE_SLOTS*ENTRIES];

  logic [19:0] base_r;
  logic [10:0] kcount_r;
  logic [4:0]  first_r;
  logic [8:0]  next_slot_r, next_slot_nxt;

  state_t state_r, state_nxt;
  in_item_t item_r;
  out_item_t res_r, res_nxt;
  out_item_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [10:0] cnt_r, cnt_nxt;
  logic [31:0] de_r, de_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic shared_r, shared_nxt;

  logic [31:0] dir_q, kdir_q, store_q;

  // memory control
  logic dir_we, kdir_we, store_we;
  logic [31:0] dir_wd, kdir_wd, store_wd;
  logic [IDX_W-1:0] d_addr, k_addr;
  logic [STORE_W-1:0] s_addr;

  wire [IDX_W-1:0] di = item_r.vaddr[31:22];
  wire [IDX_W-1:0] ti = item_r.vaddr[21:12];
  wire user_req = item_r.flags[2];
  wire [19:0] q_rel = dir_q[31:12] - base_r;
  wire q_outside = (q_rel >= 20'(TABLE_SLOTS));
  wire [8:0] alloc_s = 9'(first_r) + next_slot_r;
  wire [31:0] new_pte = {item_r.paddr[31:12], item_r.flags | 12'h001};
  wire [10:0] kn = (kcount_r > 11'(ENTRIES)) ? 11'(ENTRIES) : kcount_r;

  always_ff @(posedge clk) begin
    if (dir_we) dir_mem[d_addr] <= dir_wd;
    dir_q <= dir_mem[di];
    if (kdir_we) kdir_mem[k_addr] <= kdir_wd;
    kdir_q <= kdir_mem[k_addr];
    if (store_we) store_mem[s_addr] <= store_wd;
    store_q <= store_mem[s_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      out_valid_r <= 1'b0;
      cnt_r <= '0;
      base_r <= '0;
      kcount_r <= 11'd1;
      first_r <= '0;
      next_slot_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r <= cnt_nxt;
      next_slot_r <= next_slot_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_BASE: base_r <= cfg_data;
          CFG_KCOUNT: kcount_r <= cfg_data[10:0];
          CFG_FIRST: first_r <= cfg_data[4:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) item_r <= in_data;
    res_r <= res_nxt;
    out_r <= out_nxt;
    de_r <= de_nxt;
    slot_r <= slot_nxt;
    shared_r <= shared_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: if (cnt_r == 11'(ENTRIES - 1)) state_nxt = S_IDLE;
      S_IDLE: if (in_valid && in_ready) state_nxt = S_DREAD;
      S_DREAD: state_nxt = S_DEC;
      S_DEC: begin
        case (item_r.action)
          ACT_XLATE, ACT_UCHECK, ACT_UNMAP:
            state_nxt = (!dir_q[0] || q_outside) ? S_DONE : S_TREAD;
          ACT_MAP: begin
            if (!dir_q[0]) state_nxt = (alloc_s >= 9'(TABLE_SLOTS)) ? S_DONE : S_CLEAR;
            else if (q_outside) state_nxt = S_DONE;
            else if (user_req) state_nxt = S_KSCAN;
            else state_nxt = S_TREAD;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_KSCAN: if (cnt_r == kn) state_nxt = S_KWAIT;
      S_KWAIT: state_nxt = shared_r ? S_DONE : S_TREAD;
      S_CLEAR: if (cnt_r == 11'(ENTRIES)) state_nxt = S_DONE;
      S_TREAD: state_nxt = S_TDEC;
      S_TDEC: state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    res_nxt = res_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    next_slot_nxt = next_slot_r;
    cnt_nxt = cnt_r;
    de_nxt = de_r;
    slot_nxt = slot_r;
    shared_nxt = shared_r;
    dir_we = 1'b0; dir_wd = '0;
    kdir_we = 1'b0; kdir_wd = '0;
    store_we = 1'b0; store_wd = '0;
    d_addr = di;
    k_addr = cnt_r[IDX_W-1:0];
    s_addr = {slot_r, ti};
    in_ready = (state_r == S_IDLE);
    case (state_r)
      S_INIT: begin
        d_addr = cnt_r[IDX_W-1:0];
        dir_we = 1'b1;
        kdir_we = 1'b1;
        cnt_nxt = cnt_r + 11'd1;
      end
      S_IDLE: begin
        res_nxt = '0;
        cnt_nxt = '0;
        shared_nxt = 1'b0;
      end
      S_DEC: begin
        de_nxt = dir_q;
        slot_nxt = q_rel[SLOT_W-1:0];
        case (item_r.action)
          ACT_XLATE, ACT_UCHECK, ACT_UNMAP: begin
            if (!dir_q[0]) res_nxt.status = ST_NOMAP;
            else if (q_outside) res_nxt.status = ST_OUTSIDE;
          end
          ACT_MAP: begin
            if (!dir_q[0]) begin
              if (alloc_s >= 9'(TABLE_SLOTS)) res_nxt.status = ST_NOFREE;
              else begin
                slot_nxt = alloc_s[SLOT_W-1:0];
                next_slot_nxt = next_slot_r + 9'd1;
                dir_we = 1'b1;
                dir_wd = {base_r + 20'(alloc_s), 9'd0, user_req, 2'b11};
              end
            end else if (q_outside)
              res_nxt.status = ST_OUTSIDE;
          end
          ACT_KSET: begin
            k_addr = di;
            dir_we = 1'b1; dir_wd = new_pte;
            kdir_we = 1'b1; kdir_wd = new_pte;
          end
          default: ;
        endcase
      end
      S_KSCAN: begin
        // read data is registered, so it belongs to the previous address
        if (cnt_r != 11'd0 && kdir_q[0] && kdir_q[31:12] == de_r[31:12])
          shared_nxt = 1'b1;
        if (cnt_r != kn) cnt_nxt = cnt_r + 11'd1;
      end
      S_KWAIT: begin
        if (shared_r) res_nxt.status = ST_KSHARED;
        else begin
          dir_we = 1'b1; dir_wd = de_r | 32'h4;
        end
      end
      S_CLEAR: begin
        s_addr = {slot_r, cnt_r[IDX_W-1:0]};
        store_we = 1'b1;
        store_wd = (cnt_r[IDX_W-1:0] == ti) ? new_pte : 32'd0;
        cnt_nxt = cnt_r + 11'd1;
      end
      S_TDEC: begin
        case (item_r.action)
          ACT_XLATE, ACT_UCHECK: begin
            if (!store_q[0]) res_nxt.status = ST_NOMAP;
            else begin
              res_nxt.phys_out = {store_q[31:12], item_r.vaddr[11:0]};
              res_nxt.user_ok = store_q[2];
            end
          end
          ACT_UNMAP: begin
            if (!store_q[0]) res_nxt.status = ST_NOMAP;
            else begin store_we = 1'b1; store_wd = '0; end
          end
          default: begin
            if (store_q[0]) res_nxt.status = ST_NOMAP;
            else begin store_we = 1'b1; store_wd = new_pte; end
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_nxt = res_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_slot_bump: assert property (@(posedge clk) disable iff (!rst_n)
    (next_slot_r != $past(next_slot_r)) |-> ($past(state_r) == S_DEC)) else
    $error("slot counter moved outside decode");
  a_clear_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (cnt_r <= 11'(ENTRIES))) else $error("clear overrun");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data))) else
    $error("result changed while stalled");

endmodule

>>> bench/two_level_page_table_manager_test.sv
// testbench for the two level page table manager: random walks, maps and unmaps checked
`timescale 1ns / 1ps

module two_level_page_table_manager_test;
  import tlptm_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_BASE;
  logic [CFG_W-1:0] cfg_data = '0;

  two_level_page_table_manager dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow state of the manager
  logic [31:0] pd_mirror [ENTRIES];
  logic [31:0] kd_mirror [ENTRIES];
  logic [31:0] pt_mirror [TABLE_SLOTS*ENTRIES];
  bit slot_alloc [TABLE_SLOTS];
  int unsigned slots_used;
  logic [19:0] base_frame;
  logic [10:0] kcount;
  logic [4:0] first_slot;

  in_item_t pending_q[$];
  out_item_t expected_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_status[5];
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;

  // table slot addressed by a directory entry, -1 when outside the store
  function automatic int table_slot(logic [31:0] e);
    logic [19:0] rel;
    rel = e[31:12] - base_frame;
    if (rel >= TABLE_SLOTS) return -1;
    return int'(rel);
  endfunction

  function automatic bit shared_with_kernel(logic [31:0] e);
    int n;
    n = (kcount > ENTRIES) ? ENTRIES : kcount;
    for (int k = 0; k < n; k++)
      if (kd_mirror[k][0] && kd_mirror[k][31:12] == e[31:12]) return 1'b1;
    return 1'b0;
  endfunction

  // random slot that the allocator has handed out, -1 when there is none
  function automatic int pick_alloc_slot();
    int cand[$];
    for (int s = 0; s < TABLE_SLOTS; s++)
      if (slot_alloc[s]) cand.push_back(s);
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(cand.size() - 1, 0)];
  endfunction

  function automatic out_item_t walk_and_update(in_item_t it);
    out_item_t r;
    logic [9:0] di, ti;
    logic [31:0] de, pte, page;
    int s;
    int unsigned ns;
    r = '0;
    di = it.vaddr[31:22];
    ti = it.vaddr[21:12];
    de = pd_mirror[di];
    s = table_slot(de);
    page = {it.paddr[31:12], 12'h000};
    case (it.action)
      ACT_XLATE, ACT_UCHECK: begin
        if (!de[0]) r.status = ST_NOMAP;
        else if (s < 0) r.status = ST_OUTSIDE;
        else begin
          pte = pt_mirror[s*ENTRIES + ti];
          if (!pte[0]) r.status = ST_NOMAP;
          else begin
            r.phys_out = {pte[31:12], it.vaddr[11:0]};
            r.user_ok = pte[2];
          end
        end
      end
      ACT_MAP: begin
        if (!de[0]) begin
          ns = first_slot + slots_used;
          if (ns >= TABLE_SLOTS) r.status = ST_NOFREE;
          else begin
            slots_used++;
            slot_alloc[ns] = 1'b1;
            for (int i = 0; i < ENTRIES; i++) pt_mirror[ns*ENTRIES + i] = '0;
            pd_mirror[di] = {base_frame + 20'(ns), 9'd0, it.flags[2], 2'b11};
            pt_mirror[ns*ENTRIES + ti] = page | it.flags | 32'd1;
          end
        end else if (s < 0) r.status = ST_OUTSIDE;
        else if (it.flags[2] && shared_with_kernel(de)) r.status = ST_KSHARED;
        else begin
          if (it.flags[2]) pd_mirror[di] = de | 32'd4;
          if (pt_mirror[s*ENTRIES + ti][0]) r.status = ST_NOMAP;
          else pt_mirror[s*ENTRIES + ti] = page | it.flags | 32'd1;
        end
      end
      ACT_UNMAP: begin
        if (!de[0]) r.status = ST_NOMAP;
        else if (s < 0) r.status = ST_OUTSIDE;
        else if (!pt_mirror[s*ENTRIES + ti][0]) r.status = ST_NOMAP;
        else pt_mirror[s*ENTRIES + ti] = '0;
      end
      ACT_KSET: begin
        kd_mirror[di] = page | it.flags | 32'd1;
        pd_mirror[di] = page | it.flags | 32'd1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result %0d: %s got %h expected %h", n_checked, what, got, want);
    errors++;
  endtask

  // driver: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_q.push_back(walk_and_update(in_data));
        n_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_data <= pending_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(12, 1);
            gap_left <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor with its own stall pattern
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transfer, status", 32'(out_data.status), 32'd0);
        end else begin
          out_item_t w;
          w = expected_q.pop_front();
          if (out_data.status !== w.status)
            report_mismatch("status", 32'(out_data.status), 32'(w.status));
          if (out_data.phys_out !== w.phys_out)
            report_mismatch("phys_out", out_data.phys_out, w.phys_out);
          if (out_data.user_ok !== w.user_ok)
            report_mismatch("user_ok", 32'(out_data.user_ok), 32'(w.user_ok));
          if (w.status <= ST_OUTSIDE) n_status[w.status]++;
          n_checked++;
        end
      end
      stall_phase <= (stall_phase + 1) % 37;
      if (hold_off) out_ready <= 1'b0;
      else if (stall_phase < 12) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(3, 0) != 0);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_BASE: base_frame = val[19:0];
      CFG_KCOUNT: kcount = val[10:0];
      CFG_FIRST: first_slot = val[4:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (1100) @(posedge clk);
  endtask

  function automatic in_item_t make_op(logic [2:0] a, logic [31:0] v, logic [31:0] p,
                                       logic [11:0] f);
    in_item_t it;
    it.action = a; it.vaddr = v; it.paddr = p; it.flags = f;
    return it;
  endfunction

  // random item; directory indexes mostly from a small pool to hit existing tables
  function automatic in_item_t random_op(bit kernel_ok);
    in_item_t it;
    logic [9:0] di;
    int pick;
    it.vaddr = $urandom();
    it.paddr = $urandom();
    it.flags = $urandom_range(4095, 0);
    di = ($urandom_range(9, 0) < 8) ? 10'($urandom_range(7, 0)) : 10'($urandom());
    // the pool index, 0 included, goes into the directory bits of the address
    it.vaddr[31:22] = di;
    if ($urandom_range(3, 0) != 0) it.vaddr[21:12] = 10'($urandom_range(15, 0));
    pick = $urandom_range(99, 0);
    if (pick < 30) it.action = ACT_MAP;
    else if (pick < 55) it.action = ACT_XLATE;
    else if (pick < 75) it.action = ACT_UCHECK;
    else if (pick < 92) it.action = ACT_UNMAP;
    else if (pick < 96 && kernel_ok) it.action = ACT_KSET;
    else it.action = 3'($urandom_range(7, 5));
    return it;
  endfunction

  // kernel entries that point at allocated slots or outside the store
  function automatic in_item_t kernel_op(int unsigned slot_frame, logic [9:0] di);
    return make_op(ACT_KSET, {di, 22'($urandom())},
                   {20'(slot_frame), 12'($urandom())}, 12'($urandom()));
  endfunction

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      pd_mirror[i] = '0;
      kd_mirror[i] = '0;
    end
    for (int i = 0; i < TABLE_SLOTS*ENTRIES; i++) pt_mirror[i] = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) slot_alloc[i] = 1'b0;
    slots_used = 0;
    base_frame = '0;
    kcount = 11'd1;
    first_slot = '0;
    foreach (n_status[i]) n_status[i] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    write_reg(CFG_BASE, 20'h00100);
    write_reg(CFG_KCOUNT, 20'd1024);
    write_reg(CFG_FIRST, 20'd0);

    // directed part
    pending_q.push_back(make_op(ACT_XLATE, 32'h0000_0000, '0, '0));
    pending_q.push_back(make_op(ACT_UNMAP, 32'hFFFF_FFFF, '0, '0));
    pending_q.push_back(make_op(ACT_MAP, 32'h0000_0ABC, 32'hFFFF_FFFF, 12'h000));
    pending_q.push_back(make_op(ACT_MAP, 32'h0000_0123, 32'h1234_5678, 12'h000));
    pending_q.push_back(make_op(ACT_XLATE, 32'h0000_0FFF, '0, '0));
    pending_q.push_back(make_op(ACT_UCHECK, 32'h0000_0000, '0, '0));
    pending_q.push_back(make_op(ACT_MAP, 32'hFFC0_1000, 32'hFFFF_F000, 12'hFFF));
    pending_q.push_back(make_op(ACT_UCHECK, 32'hFFC0_1FFF, 32'hFFFF_FFFF, 12'hFFF));
    pending_q.push_back(make_op(ACT_MAP, 32'h0000_2000, 32'hAAAA_A000, 12'h004));
    pending_q.push_back(make_op(ACT_UCHECK, 32'h0000_2555, '0, '0));
    // kernel entry sharing slot 0 (dir 0's table), then user map through it
    pending_q.push_back(kernel_op(32'h00100, 10'd1));
    pending_q.push_back(make_op(ACT_MAP, 32'h0040_3000, 32'h5555_5000, 12'h004));
    pending_q.push_back(make_op(ACT_MAP, 32'h0000_3000, 32'h5555_5000, 12'h004));
    pending_q.push_back(make_op(ACT_MAP, 32'h0040_3000, 32'h5555_5000, 12'h002));
    pending_q.push_back(make_op(ACT_XLATE, 32'h0040_3123, '0, '0));
    // kernel entry outside the store under every base used here
    pending_q.push_back(kernel_op(32'h80000, 10'd2));
    pending_q.push_back(make_op(ACT_XLATE, 32'h0080_0000, '0, '0));
    pending_q.push_back(make_op(ACT_MAP, 32'h0080_0000, '0, 12'h001));
    pending_q.push_back(make_op(ACT_UNMAP, 32'h0080_0000, '0, '0));
    pending_q.push_back(make_op(ACT_UNMAP, 32'h0000_0000, '0, '0));
    pending_q.push_back(make_op(ACT_XLATE, 32'h0000_0000, '0, '0));
    pending_q.push_back(make_op(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF));
    pending_q.push_back(make_op(3'd7, 32'h1234_5678, 32'h1, 12'h1));
    drain();

    // random phases under different settings; directory keeps its contents
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: begin write_reg(CFG_KCOUNT, 20'd1); end
        2: begin write_reg(CFG_FIRST, 20'd16); end
        3: begin write_reg(CFG_BASE, 20'hFFFF8); write_reg(CFG_FIRST, 20'd2); end
        4: begin write_reg(CFG_KCOUNT, 20'd2047); write_reg(CFG_BASE, 20'h00100); end
        5: begin write_reg(CFG_FIRST, 20'd31); write_reg(CFG_KCOUNT, 20'd3); end
        default: ;
      endcase
      for (int i = 0; i < 93; i++) begin
        int ks;
        // kernel entries only point at allocated slots or far outside the store
        if ($urandom_range(30, 0) == 0) begin
          ks = pick_alloc_slot();
          if (ks >= 0 && $urandom_range(1, 0) == 1)
            pending_q.push_back(kernel_op(32'(base_frame) + 32'(ks),
                                          10'($urandom_range(1023, 8))));
          else
            pending_q.push_back(kernel_op(32'h80000 + $urandom_range(999, 0),
                                          10'($urandom_range(1023, 8))));
        end else begin
          pending_q.push_back(random_op(1'b0));
        end
      end
      if (ph == 2) begin
        // long receiver hold-off while the sender keeps offering
        fork
          begin
            hold_off = 1'b1;
            repeat (3000) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      drain();
    end

    $display("run covered %0d items in 7 settings, %0d results checked", n_sent, n_checked);
    $display("status counts ok %0d nomap %0d nofree %0d kshared %0d outside %0d",
             n_status[0], n_status[1], n_status[2], n_status[3], n_status[4]);
    if (errors == 0 && expected_q.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #60ms;
    $display("timeout with %0d results outstanding", expected_q.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
